// ===== rtl/additive_dds_synth_dac_macros.svh =====
// Assertion macros shared by the additive DDS synthesizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADDITIVE_DDS_SYNTH_DAC_MACROS_SVH
`define ADDITIVE_DDS_SYNTH_DAC_MACROS_SVH

// implication in the same cycle
`define ADDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property failed");

// implication in the next cycle
`define ADDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

// ===== rtl/adds_pkg.sv =====
// Package for the additive DDS synthesizer: widths, codes, stage structs
// and a Q16 200*sin lookup table built at elaboration. No dependencies.
`default_nettype none

package adds_pkg;

  localparam int CHANNELS_DEF = 32;
  localparam int OP_W         = 2;
  localparam int CHAN_W       = 5;
  localparam int VALUE_W      = 32;
  localparam int PHASE_W      = 32;
  localparam int AMP_W        = 8;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_AW      = 8;
  localparam int SINE_W       = 25;
  localparam int SAMPLE_W     = 12;
  localparam int WORD_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = 12;
  localparam int SAMPLE_MAX   = 4095;
  localparam int OFFSET_RST   = 2048;

  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_AMPLITUDE = 2'd1;
  localparam logic [OP_W-1:0] OP_INCREMENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_DAC_B  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_UNITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ACTIVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_OFFSET = 2'd3;

  localparam logic [63:0] Q60_PI      = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
  localparam logic [63:0] SINE_SCALE  = 64'd13107200;

  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_rom_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SINE_AW-1:0] idx;
    logic [AMP_W-1:0]   amp;
  } mix_in_t;

  typedef struct packed {
    logic                done;
    logic                clip;
    logic [SAMPLE_W-1:0] sample;
  } mix_out_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series in Q60, same integer steps as the behavioral definition
  function automatic sine_t sine_entry(input int unsigned idx);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [31:0] v;
    logic        neg;
    n = 64'(idx) * 64'd6283;
    a = ((n / 64'd125) << 49) + (((n % 64'd125) << 49) / 64'd125);
    neg = 1'b0;
    if (a >= Q60_PI) begin
      a = a - Q60_PI;
      neg = 1'b1;
    end
    if (a > Q60_HALF_PI) a = Q60_PI - a;
    x2 = mul_q60(a, a);
    term = a;
    sum = a;
    for (int k = 1; k <= 12; k++) begin
      term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    mag = mul_q60(sum, SINE_SCALE);
    v = mag[31:0];
    if (neg) v = -v;
    return sine_t'(v[SINE_W-1:0]);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int i = 0; i < SINE_ENTRIES; i++) t[i] = sine_entry(i);
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/adds_if.sv =====
// Valid/ready channel interfaces: command items in, DAC word items out.
// Depends on adds_pkg for field widths.
`default_nettype none

interface adds_cmd_if import adds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CHAN_W-1:0]  channel;
  logic [VALUE_W-1:0] value;

  modport source(output valid, operation, channel, value, input ready);
  modport sink(input valid, operation, channel, value, output ready);
endinterface

interface adds_dac_if import adds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] dac_word;
  logic              clipped;

  modport source(output valid, dac_word, clipped, input ready);
  modport sink(input valid, dac_word, clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/additive_dds_synth_dac.sv =====
// Top level of the additive DDS synthesizer: sequencer, phase and
// parameter memories, config registers, output register.
// Depends on adds_pkg, adds_if, adds_ram, adds_mix and the macro header.
//
//   port      kind         role
//   cmd       valid/ready  tick, amplitude or increment items in
//   dac       valid/ready  DAC control word items out
//   cfg_*     write only   control bits and output offset
//
// A tick item steps through the channels once it is accepted: one
// channel per cycle through the memory read ports, then table lookup, multiply,
// sum and the output register; the next item can be taken once the result is loaded.
// A load item is a read-modify-write of the parameter memory (S_MERGE);
// an unknown operation or a load to a channel out of range is dropped.
// Reset is synchronous; the stores read as zero through valid bits at once.
// A finished result waits in the output register; loads are taken meanwhile,
// and the next tick completes once that result has been taken.
`default_nettype none

`include "additive_dds_synth_dac_macros.svh"

module additive_dds_synth_dac import adds_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  adds_cmd_if.sink                  cmd,
  adds_dac_if.source                dac,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PRM_W = PHASE_W + AMP_W;
  localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MERGE = 4'b0010,
    S_TICK  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t              state;
  logic [AW-1:0]       cnt;
  logic                sel_b;
  logic                gain;
  logic                active;
  logic [SAMPLE_W-1:0] offset;
  logic [OP_W-1:0]     wr_op;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_value;
  logic [CHANNELS-1:0] param_valid;
  logic                phase_live;
  logic                st1_valid;
  logic                st1_last;
  logic [AW-1:0]       st1_addr;

  logic                accept;
  logic                chan_ok;
  logic                finish;
  logic                mix_clear;
  logic [AW-1:0]       prm_raddr;
  logic [PRM_W-1:0]    prm_rdata;
  logic [PRM_W-1:0]    prm_old;
  logic [PRM_W-1:0]    prm_wdata;
  logic                prm_we;
  logic [PHASE_W-1:0]  ph_rdata;
  logic [PHASE_W-1:0]  ph_new;
  logic [PRM_W-1:0]    prm_st1;
  mix_in_t             feed;
  mix_out_t            status;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign chan_ok   = 32'(cmd.channel) < 32'(CHANNELS);
  assign mix_clear = accept && (cmd.operation == OP_TICK);
  assign finish    = (state == S_DRAIN) && status.done && (!dac.valid || dac.ready);
  assign prm_raddr = (state == S_IDLE) ? AW'(cmd.channel) : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_b  <= 1'b0;
      gain   <= 1'b1;
      active <= 1'b1;
      offset <= SAMPLE_W'(OFFSET_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECT_DAC_B:  sel_b  <= cfg_data[0];
        CFG_GAIN_UNITY:    gain   <= cfg_data[0];
        CFG_OUTPUT_ACTIVE: active <= cfg_data[0];
        CFG_OUTPUT_OFFSET: offset <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_TICK) begin
              state <= S_TICK;
              cnt   <= '0;
            end else if ((cmd.operation == OP_AMPLITUDE || cmd.operation == OP_INCREMENT)
                         && chan_ok) begin
              state <= S_MERGE;
            end
          end
        end
        S_MERGE: state <= S_IDLE;
        S_TICK: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_op    <= cmd.operation;
      wr_addr  <= AW'(cmd.channel);
      wr_value <= cmd.value;
    end
  end

  // parameter entry is {increment, amplitude}; merge the written half
  assign prm_old = param_valid[wr_addr] ? prm_rdata : '0;
  assign prm_we  = (state == S_MERGE);
  always_comb begin
    if (wr_op == OP_AMPLITUDE) prm_wdata = {prm_old[PRM_W-1:AMP_W], wr_value[AMP_W-1:0]};
    else prm_wdata = {wr_value[PHASE_W-1:0], prm_old[AMP_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      param_valid <= '0;
      phase_live  <= 1'b0;
      st1_valid   <= 1'b0;
    end else begin
      if (prm_we) param_valid[wr_addr] <= 1'b1;
      if (st1_valid && st1_last) phase_live <= 1'b1;
      st1_valid <= (state == S_TICK);
    end
    st1_last <= (cnt == LAST);
    st1_addr <= cnt;
  end

  adds_ram #(.WIDTH(PRM_W), .DEPTH(CHANNELS)) u_param_ram (
    .clk   (clk),
    .we    (prm_we),
    .waddr (wr_addr),
    .wdata (prm_wdata),
    .raddr (prm_raddr),
    .rdata (prm_rdata)
  );

  adds_ram #(.WIDTH(PHASE_W), .DEPTH(CHANNELS)) u_phase_ram (
    .clk   (clk),
    .we    (st1_valid),
    .waddr (st1_addr),
    .wdata (ph_new),
    .raddr (cnt),
    .rdata (ph_rdata)
  );

  assign prm_st1 = param_valid[st1_addr] ? prm_rdata : '0;
  assign ph_new  = (phase_live ? ph_rdata : '0) + prm_st1[PRM_W-1:AMP_W];

  always_comb begin
    feed.valid = st1_valid;
    feed.last  = st1_last;
    feed.idx   = ph_new[PHASE_W-1 -: SINE_AW];
    feed.amp   = prm_st1[AMP_W-1:0];
  end

  adds_mix #(.CHANNELS(CHANNELS)) u_mix (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .clear  (mix_clear),
    .offset (offset),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dac.valid <= 1'b0;
    end else if (finish) begin
      dac.valid <= 1'b1;
    end else if (dac.ready) begin
      dac.valid <= 1'b0;
    end
    if (finish) begin
      dac.dac_word <= {sel_b, 1'b0, gain, active, status.sample};
      dac.clipped  <= status.clip;
    end
  end

  `ADDS_ASSERT_IMP(a_phase_wr_in_tick, clk, rst, st1_valid,
                   state == S_TICK || state == S_DRAIN)
  `ADDS_ASSERT_IMP(a_idle_pipe_empty, clk, rst, state == S_IDLE, !st1_valid)
  `ADDS_ASSERT_NXT(a_result_from_drain, clk, rst, finish, dac.valid && state == S_IDLE)
  `ADDS_ASSERT_IMP(a_merge_after_load, clk, rst, state == S_MERGE,
                   $past(accept) && $past(cmd.operation) != OP_TICK)

endmodule

`default_nettype wire

// ===== rtl/adds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on adds_pkg for default sizes.
`default_nettype none

module adds_ram import adds_pkg::*; #(
  parameter int  WIDTH = PHASE_W,
  parameter int  DEPTH = CHANNELS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/adds_mix.sv =====
// Mixer pipeline: sine table lookup, amplitude multiply, running sum,
// offset and saturation of the final sum. Depends on adds_pkg.
`default_nettype none

module adds_mix import adds_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mix_in_t             feed,
  input  wire logic                clear,
  input  wire logic [SAMPLE_W-1:0] offset,
  output      mix_out_t            status
);

  localparam int PROD_W  = AMP_W + 1 + SINE_W;
  localparam int TERM_W  = PROD_W - 6;
  localparam int ACC_W   = TERM_W + $clog2(CHANNELS) + 1;
  localparam int LEVEL_W = ACC_W - 16 + 2;
  localparam logic signed [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(SAMPLE_MAX);

  logic                     a_valid;
  logic                     a_last;
  sine_t                    a_sine;
  logic [AMP_W-1:0]         a_amp;
  logic                     b_valid;
  logic                     b_last;
  logic signed [TERM_W-1:0] b_term;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;
  logic signed [PROD_W-1:0] prod;
  logic signed [LEVEL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= feed.valid;
      b_valid <= a_valid;
    end
    a_last <= feed.last;
    a_sine <= sine_t'(SINE_ROM[feed.idx]);
    a_amp  <= feed.amp;
    b_last <= a_last;
    b_term <= prod[PROD_W-1:6];
  end

  // signed product, then arithmetic shift gives the floor of amp*sin/64
  assign prod = PROD_W'(signed'({1'b0, a_amp})) * PROD_W'(a_sine);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (clear) begin
      done <= 1'b0;
    end else if (b_valid && b_last) begin
      done <= 1'b1;
    end
    if (clear) acc <= '0;
    else if (b_valid) acc <= acc + ACC_W'(b_term);
  end

  always_comb begin
    level = LEVEL_W'(signed'(acc[ACC_W-1:16])) + LEVEL_W'(offset);
    status.done = done;
    if (level[LEVEL_W-1]) begin
      status.sample = '0;
      status.clip   = 1'b1;
    end else if (level > LVL_MAX) begin
      status.sample = SAMPLE_W'(SAMPLE_MAX);
      status.clip   = 1'b1;
    end else begin
      status.sample = level[SAMPLE_W-1:0];
      status.clip   = 1'b0;
    end
  end

endmodule

`default_nettype wire
